@@ sv/pfpe_pkg.sv @@
package pfpe_pkg;

    // Panel geometry.
    localparam int COLUMNS = 128;
    localparam int ROWS    = 64;

    // Derived sizes.
    localparam int AW     = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
    localparam int GROUPS = (COLUMNS + 7) / 8;
    localparam int GW     = (GROUPS > 1) ? $clog2(GROUPS) : 1;
    localparam int CW     = GW + 3;

    // Bits of rows that exist on the panel.
    localparam logic [63:0] ROW_MASK =
        (ROWS >= 64) ? {64{1'b1}} : ((64'd1 << ROWS) - 64'd1);

    // Header bytes of a page readout.
    localparam logic [7:0] PAGE_CMD_BASE = 8'hb0;
    localparam logic [7:0] COL_HI_CMD    = 8'h10;
    localparam logic [7:0] BYTE_MASK     = 8'hff;

    // Command codes.
    localparam logic [1:0] CMD_POINT = 2'd0;
    localparam logic [1:0] CMD_FILL  = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    // Pen codes.
    localparam logic [1:0] PEN_ERASE  = 2'd0;
    localparam logic [1:0] PEN_SET    = 2'd1;
    localparam logic [1:0] PEN_INVERT = 2'd2;

    // Result kinds.
    localparam logic KIND_HEADER = 1'b0;
    localparam logic KIND_DATA   = 1'b1;

    // Sequencer states.
    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_PT_WR = 6'b000010,
        S_FILL  = 6'b000100,
        S_HDR   = 6'b001000,
        S_RD    = 6'b010000,
        S_PUSH  = 6'b100000
    } t_state;

endpackage

@@ sv/page_framebuffer_pixel_engine.sv @@
// Monochrome page-organized frame store with a pixel engine. Each panel column is one
// 64-bit word in a single-port synchronous memory, cleared at reset by per-column valid
// bits. One request is worked at a time: a point reads the column, then modifies it and
// writes it back, a fill takes the accepting cycle and then writes one column per cycle,
// and a page readout reads one column a cycle through the memory's one read port,
// waiting while the output stalls, and gives one header and GROUPS data words.
// The next request is taken as soon as the sequencer is back in idle, even while the last
// result still waits in the output register.
module page_framebuffer_pixel_engine (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // cmd[1:0], pos_x[9:2], pos_y[17:10], pen[19:18], page_sel[22:20], zero [23]
    input  logic [23:0] i_s_axis_tdata,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // word[63:0]
    output logic [63:0] o_m_axis_tdata,
    // kind[0]
    output logic        o_m_axis_tuser,
    output logic        o_m_axis_tlast
);

    localparam int AWL = pfpe_pkg::AW;

    // Request fields.
    logic [1:0] in_cmd;
    logic [7:0] in_x;
    logic [7:0] in_y;
    logic [1:0] in_pen;
    logic [2:0] in_page;

    assign in_cmd  = i_s_axis_tdata[1:0];
    assign in_x    = i_s_axis_tdata[9:2];
    assign in_y    = i_s_axis_tdata[17:10];
    assign in_pen  = i_s_axis_tdata[19:18];
    assign in_page = i_s_axis_tdata[22:20];

    pfpe_pkg::t_state r_state, n_state;

    logic            r_o_valid;
    logic [63:0]     r_o_word;
    logic            r_o_kind;
    logic            r_o_last;

    logic [AWL-1:0]  r_pt_addr;
    logic [5:0]      r_pt_row;
    logic [1:0]      r_pen;
    logic [2:0]      r_page;
    logic [AWL-1:0]  r_fcol;
    logic [63:0]     r_fill_val;
    logic [pfpe_pkg::GW-1:0] r_grp;
    logic [2:0]      r_lane;
    logic            r_pend;
    logic [2:0]      r_pend_lane;
    logic [63:0]     r_acc;

    logic [63:0]             r_mem [pfpe_pkg::COLUMNS];
    logic [pfpe_pkg::COLUMNS-1:0] r_vld;
    logic [63:0]             r_q;
    logic                    r_q_vld;

    logic            accept;
    logic            out_free;
    logic            pt_on_panel;
    logic [pfpe_pkg::CW-1:0] rd_col;
    logic            rd_col_ok;
    logic            last_grp;
    logic            mem_re;
    logic [AWL-1:0]  mem_ra;
    logic            mem_we;
    logic [AWL-1:0]  mem_wa;
    logic [63:0]     mem_wd;
    logic [63:0]     q_eff;
    logic [63:0]     pt_bit;
    logic [7:0]      rd_byte;
    logic [63:0]     hdr_word;

    assign o_s_axis_tready = (r_state == pfpe_pkg::S_IDLE);
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free        = !r_o_valid || i_m_axis_tready;

    assign pt_on_panel = ({1'b0, in_x} < 9'(pfpe_pkg::COLUMNS)) &&
                         ({1'b0, in_y} < 9'(pfpe_pkg::ROWS));

    // Column being read during a readout.
    assign rd_col    = {r_grp, r_lane};
    assign rd_col_ok = ({1'b0, rd_col} < (pfpe_pkg::CW + 1)'(pfpe_pkg::COLUMNS));
    assign last_grp  = (r_grp == pfpe_pkg::GW'(pfpe_pkg::GROUPS - 1));

    // An entry never written since reset reads as zero.
    assign q_eff   = r_q_vld ? r_q : 64'd0;
    assign rd_byte = q_eff[r_page * 8 +: 8] & pfpe_pkg::BYTE_MASK;
    assign pt_bit  = 64'd1 << r_pt_row;

    assign hdr_word = {40'd0, pfpe_pkg::COL_HI_CMD,
                       pfpe_pkg::PAGE_CMD_BASE + {5'd0, r_page}, 8'd0};

    // Memory port selection.
    always_comb begin
        mem_re = 1'b0;
        mem_ra = in_x[AWL-1:0];
        mem_we = 1'b0;
        mem_wa = r_pt_addr;
        mem_wd = q_eff & ~pt_bit;
        if (accept && (in_cmd == pfpe_pkg::CMD_POINT) && pt_on_panel) begin
            mem_re = 1'b1;
        end
        if (r_state == pfpe_pkg::S_RD) begin
            mem_re = rd_col_ok;
            mem_ra = rd_col[AWL-1:0];
        end
        if (r_state == pfpe_pkg::S_PT_WR) begin
            mem_we = 1'b1;
            case (r_pen)
                pfpe_pkg::PEN_SET:    mem_wd = q_eff | pt_bit;
                pfpe_pkg::PEN_INVERT: mem_wd = q_eff ^ pt_bit;
                default:              mem_wd = q_eff & ~pt_bit;
            endcase
        end
        if (r_state == pfpe_pkg::S_FILL) begin
            mem_we = 1'b1;
            mem_wa = r_fcol;
            mem_wd = r_fill_val;
        end
    end

    // Frame store array.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            r_q <= r_mem[mem_ra];
        end
    end

    // Valid bits give the cleared store after reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= '0;
            r_q_vld <= 1'b0;
        end else begin
            if (mem_we) begin
                r_vld[mem_wa] <= 1'b1;
            end
            if (mem_re) begin
                r_q_vld <= r_vld[mem_ra];
            end
        end
    end

    // Sequencer next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            pfpe_pkg::S_IDLE: begin
                if (accept) begin
                    case (in_cmd)
                        pfpe_pkg::CMD_POINT: begin
                            if (pt_on_panel) n_state = pfpe_pkg::S_PT_WR;
                        end
                        pfpe_pkg::CMD_FILL: begin
                            if (in_pen == pfpe_pkg::PEN_SET ||
                                in_pen == pfpe_pkg::PEN_ERASE) begin
                                n_state = pfpe_pkg::S_FILL;
                            end
                        end
                        pfpe_pkg::CMD_READ: n_state = pfpe_pkg::S_HDR;
                        default: n_state = pfpe_pkg::S_IDLE;
                    endcase
                end
            end
            pfpe_pkg::S_PT_WR: n_state = pfpe_pkg::S_IDLE;
            pfpe_pkg::S_FILL: begin
                if (r_fcol == AWL'(pfpe_pkg::COLUMNS - 1)) n_state = pfpe_pkg::S_IDLE;
            end
            pfpe_pkg::S_HDR: begin
                if (out_free) n_state = pfpe_pkg::S_RD;
            end
            pfpe_pkg::S_RD: begin
                if (r_lane == 3'd7) n_state = pfpe_pkg::S_PUSH;
            end
            pfpe_pkg::S_PUSH: begin
                if (!r_pend && out_free) begin
                    n_state = last_grp ? pfpe_pkg::S_IDLE : pfpe_pkg::S_RD;
                end
            end
            default: n_state = pfpe_pkg::S_IDLE;
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= pfpe_pkg::S_IDLE;
            r_o_valid <= 1'b0;
            r_pend    <= 1'b0;
        end else begin
            r_state <= n_state;
            if ((r_state == pfpe_pkg::S_HDR && out_free) ||
                (r_state == pfpe_pkg::S_PUSH && !r_pend && out_free)) begin
                r_o_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_o_valid <= 1'b0;
            end
            r_pend <= (r_state == pfpe_pkg::S_RD) && rd_col_ok;
        end
    end

    // Request capture, counters and word assembly.
    always_ff @(posedge i_clk) begin
        r_pend_lane <= r_lane;
        if (accept) begin
            r_pt_addr  <= in_x[AWL-1:0];
            r_pt_row   <= in_y[5:0];
            r_pen      <= in_pen;
            r_page     <= in_page;
            r_fcol     <= '0;
            r_fill_val <= (in_pen == pfpe_pkg::PEN_SET) ? pfpe_pkg::ROW_MASK : 64'd0;
            r_grp      <= '0;
            r_lane     <= 3'd0;
            r_acc      <= 64'd0;
        end
        if (r_state == pfpe_pkg::S_FILL) begin
            r_fcol <= r_fcol + AWL'(1);
        end
        if (r_state == pfpe_pkg::S_RD) begin
            r_lane <= r_lane + 3'd1;
        end
        if (r_pend) begin
            r_acc[r_pend_lane * 8 +: 8] <= rd_byte;
        end
        if (r_state == pfpe_pkg::S_HDR && out_free) begin
            r_o_word <= hdr_word;
            r_o_kind <= pfpe_pkg::KIND_HEADER;
            r_o_last <= 1'b0;
        end
        if (r_state == pfpe_pkg::S_PUSH && !r_pend && out_free) begin
            r_o_word <= r_acc;
            r_o_kind <= pfpe_pkg::KIND_DATA;
            r_o_last <= last_grp;
            r_acc    <= 64'd0;
            r_grp    <= r_grp + pfpe_pkg::GW'(1);
        end
    end

    assign o_m_axis_tvalid = r_o_valid;
    assign o_m_axis_tdata  = r_o_word;
    assign o_m_axis_tuser  = r_o_kind;
    assign o_m_axis_tlast  = r_o_last;

endmodule

@@ sv/pfpe_checker.sv @@
module pfpe_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_axis_tvalid,
    input logic        o_s_axis_tready,
    input logic [23:0] i_s_axis_tdata,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [63:0] o_m_axis_tdata,
    input logic        o_m_axis_tuser,
    input logic        o_m_axis_tlast
);

    // No result is offered right after reset.
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result offered after reset");

    // A stalled result holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser) &&
            $stable(o_m_axis_tlast))
        else $error("stalled result changed");

    // A header carries the page command bytes and never ends a readout.
    a_header: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (o_m_axis_tuser == pfpe_pkg::KIND_HEADER) |->
            !o_m_axis_tlast && (o_m_axis_tdata[7:0] == 8'd0) &&
            (o_m_axis_tdata[15:11] == 5'b10110) &&
            (o_m_axis_tdata[23:16] == pfpe_pkg::COL_HI_CMD) &&
            (o_m_axis_tdata[63:24] == 40'd0))
        else $error("malformed header");

    // The end mark only comes on a data word.
    a_last_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tlast |-> (o_m_axis_tuser == pfpe_pkg::KIND_DATA))
        else $error("end mark on a header");

    // A readout request keeps the engine busy in the next cycle.
    a_read_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready &&
            (i_s_axis_tdata[1:0] == pfpe_pkg::CMD_READ) |=> !o_s_axis_tready)
        else $error("request taken during readout");

endmodule

bind page_framebuffer_pixel_engine pfpe_checker u_pfpe_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .i_s_axis_tdata  (i_s_axis_tdata),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser),
    .o_m_axis_tlast  (o_m_axis_tlast)
);

@@ test/page_readout_checker.sv @@
`timescale 1ns / 1ps

// Watches the request and result streams of the pixel engine. It keeps its own copy of
// the frame store, works out the header and data words of every page readout, and
// compares each result word with the oldest one still waiting.
module page_readout_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_req_valid,
    input  logic        i_req_ready,
    input  logic [23:0] i_req_data,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [63:0] i_out_data,
    input  logic        i_out_user,
    input  logic        i_out_last,
    output int          o_errors,
    output int          o_pending
);

    // One result word of a page readout.
    typedef struct packed {
        logic        kind;
        logic [63:0] word;
        logic        last;
    } t_page_word;

    logic [63:0] pixel_cols [pfpe_pkg::COLUMNS];
    t_page_word  expected_words [$];
    int          mismatch_count = 0;
    int          col_idx;

    // Update the frame store for one request and queue the words that a readout returns.
    task automatic apply_request(input logic [23:0] req);
        logic [1:0]  cmd;
        logic [7:0]  pos_x;
        logic [7:0]  pos_y;
        logic [1:0]  pen;
        logic [2:0]  page;
        logic [63:0] pixel_bit;
        t_page_word  w;
        int          grp;
        int          byte_idx;
        int          col;
        cmd   = req[1:0];
        pos_x = req[9:2];
        pos_y = req[17:10];
        pen   = req[19:18];
        page  = req[22:20];
        case (cmd)
            pfpe_pkg::CMD_POINT: begin
                // Points off the panel leave the store alone; pen code three clears.
                if (int'(pos_x) < pfpe_pkg::COLUMNS && int'(pos_y) < pfpe_pkg::ROWS) begin
                    pixel_bit = 64'd1 << pos_y;
                    if (pen == pfpe_pkg::PEN_SET) begin
                        pixel_cols[pos_x] = pixel_cols[pos_x] | pixel_bit;
                    end else if (pen == pfpe_pkg::PEN_INVERT) begin
                        pixel_cols[pos_x] = pixel_cols[pos_x] ^ pixel_bit;
                    end else begin
                        pixel_cols[pos_x] = pixel_cols[pos_x] & ~pixel_bit;
                    end
                end
            end
            pfpe_pkg::CMD_FILL: begin
                // Only write and clear change the store; rows past the panel stay zero.
                for (col = 0; col < pfpe_pkg::COLUMNS; col++) begin
                    if (pen == pfpe_pkg::PEN_SET) begin
                        pixel_cols[col] = pfpe_pkg::ROW_MASK;
                    end else if (pen == pfpe_pkg::PEN_ERASE) begin
                        pixel_cols[col] = '0;
                    end
                end
            end
            pfpe_pkg::CMD_READ: begin
                // Header first, then eight column bytes per data word.
                w.kind = pfpe_pkg::KIND_HEADER;
                w.word = {40'd0, pfpe_pkg::COL_HI_CMD,
                          (pfpe_pkg::PAGE_CMD_BASE + {5'd0, page}) & pfpe_pkg::BYTE_MASK,
                          8'h00};
                w.last = 1'b0;
                expected_words.push_back(w);
                for (grp = 0; grp < pfpe_pkg::GROUPS; grp++) begin
                    w.kind = pfpe_pkg::KIND_DATA;
                    w.word = '0;
                    for (byte_idx = 0; byte_idx < 8; byte_idx++) begin
                        col = grp * 8 + byte_idx;
                        if (col < pfpe_pkg::COLUMNS) begin
                            w.word[8 * byte_idx +: 8] = pixel_cols[col][8 * page +: 8];
                        end
                    end
                    w.last = (grp == pfpe_pkg::GROUPS - 1);
                    expected_words.push_back(w);
                end
            end
            default: begin
            end
        endcase
    endtask

    // Compare results first, then take in the request of the same edge.
    always @(posedge i_clk) begin
        t_page_word exp_w;
        if (!i_rst_n) begin
            for (col_idx = 0; col_idx < pfpe_pkg::COLUMNS; col_idx++) begin
                pixel_cols[col_idx] = '0;
            end
            expected_words.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (expected_words.size() == 0) begin
                    if (mismatch_count < 10) begin
                        $display("%0t: result word with none expected: kind=%0d word=%h last=%0d",
                                 $time, i_out_user, i_out_data, i_out_last);
                    end
                    mismatch_count++;
                end else begin
                    exp_w = expected_words.pop_front();
                    if (exp_w.kind !== i_out_user || exp_w.word !== i_out_data ||
                        exp_w.last !== i_out_last) begin
                        if (mismatch_count < 10) begin
                            $display("%0t: result mismatch: expected kind=%0d word=%h last=%0d",
                                     $time, exp_w.kind, exp_w.word, exp_w.last);
                            $display("%0t:                  got kind=%0d word=%h last=%0d",
                                     $time, i_out_user, i_out_data, i_out_last);
                        end
                        mismatch_count++;
                    end
                end
            end
            if (i_req_valid && i_req_ready) begin
                apply_request(i_req_data);
            end
        end
        o_errors  = mismatch_count;
        o_pending = expected_words.size();
    end

endmodule

@@ test/tb.sv @@
`timescale 1ns / 1ps

// Drives pixel engine requests: a directed opening, then random points, fills and page
// readouts, with idle cycles on both streams that change over three phases.
module tb;

    // Codes the package leaves unnamed.
    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam logic [1:0] PEN_UNUSED = 2'd3;

    localparam int RANDOM_REQUESTS = 136;
    localparam int DRAIN_CYCLES    = 400;
    localparam int CYCLE_LIMIT     = 1_000_000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;

    int errors;
    int pending;
    int cycle_count = 0;
    int send_idle_pct = 8;
    int recv_idle_pct = 83;
    int req_idx;

    page_framebuffer_pixel_engine dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser),
        .o_m_axis_tlast  (m_tlast)
    );

    page_readout_checker checker_i (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (s_tvalid),
        .i_req_ready (s_tready),
        .i_req_data  (s_tdata),
        .i_out_valid (m_tvalid),
        .i_out_ready (m_tready),
        .i_out_data  (m_tdata),
        .i_out_user  (m_tuser),
        .i_out_last  (m_tlast),
        .o_errors    (errors),
        .o_pending   (pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Stop a hung run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // The result side stalls at random.
    always @(negedge i_clk) begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    function automatic logic [23:0] pack_request(input logic [1:0] cmd, input logic [7:0] pos_x,
                                                 input logic [7:0] pos_y, input logic [1:0] pen,
                                                 input logic [2:0] page);
        return {1'b0, page, pen, pos_y, pos_x, cmd};
    endfunction

    // Mostly points, many of them in a small corner so that pens hit lit pixels, with
    // readouts often enough to see the store; rare fills and unused command codes.
    function automatic logic [23:0] random_request();
        int          pick;
        int          pen_pick;
        logic [1:0]  cmd;
        logic [7:0]  pos_x;
        logic [7:0]  pos_y;
        logic [1:0]  pen;
        logic [2:0]  page;
        pick     = $urandom_range(99);
        pen_pick = $urandom_range(99);
        pos_x    = 8'($urandom_range(255));
        pos_y    = 8'($urandom_range(255));
        page     = 3'($urandom_range(7));
        pen      = 2'($urandom_range(3));
        if (pick < 55) begin
            cmd = pfpe_pkg::CMD_POINT;
            if (pen_pick < 45) begin
                pen = pfpe_pkg::PEN_SET;
            end else if (pen_pick < 75) begin
                pen = pfpe_pkg::PEN_INVERT;
            end else if (pen_pick < 93) begin
                pen = pfpe_pkg::PEN_ERASE;
            end else begin
                pen = PEN_UNUSED;
            end
            case ($urandom_range(9))
                0: begin
                end
                1, 2, 3, 4: begin
                    pos_x = 8'($urandom_range(15));
                    pos_y = 8'($urandom_range(15));
                end
                default: begin
                    pos_x = 8'($urandom_range(pfpe_pkg::COLUMNS - 1));
                    pos_y = 8'($urandom_range(pfpe_pkg::ROWS - 1));
                end
            endcase
        end else if (pick < 85) begin
            cmd = pfpe_pkg::CMD_READ;
        end else if (pick < 93) begin
            cmd = pfpe_pkg::CMD_FILL;
        end else begin
            cmd = CMD_UNUSED;
        end
        return pack_request(cmd, pos_x, pos_y, pen, page);
    endfunction

    // Offer one request, with random idle cycles ahead of it, and wait for it to be taken.
    task automatic send_request(input logic [23:0] req);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= req;
        @(posedge i_clk);
        while (!s_tready) begin
            @(posedge i_clk);
        end
        @(negedge i_clk);
    endtask

    initial begin
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed opening: empty store, panel corners, off-panel points, all pens and fills.
        send_request(pack_request(pfpe_pkg::CMD_READ,  8'd0, 8'd0, pfpe_pkg::PEN_ERASE, 3'd0));
        send_request(pack_request(pfpe_pkg::CMD_POINT, 8'd0, 8'd0, pfpe_pkg::PEN_SET, 3'd0));
        send_request(pack_request(pfpe_pkg::CMD_POINT, 8'd127, 8'd63, pfpe_pkg::PEN_SET, 3'd0));
        send_request(pack_request(pfpe_pkg::CMD_POINT, 8'd128, 8'd5, pfpe_pkg::PEN_SET, 3'd0));
        send_request(pack_request(pfpe_pkg::CMD_POINT, 8'd3, 8'd64, pfpe_pkg::PEN_SET, 3'd0));
        send_request(pack_request(pfpe_pkg::CMD_POINT, 8'd255, 8'd255, pfpe_pkg::PEN_SET, 3'd7));
        send_request(pack_request(pfpe_pkg::CMD_POINT, 8'd5, 8'd10, pfpe_pkg::PEN_INVERT, 3'd0));
        send_request(pack_request(pfpe_pkg::CMD_POINT, 8'd5, 8'd11, pfpe_pkg::PEN_INVERT, 3'd0));
        send_request(pack_request(pfpe_pkg::CMD_POINT, 8'd5, 8'd10, pfpe_pkg::PEN_INVERT, 3'd0));
        send_request(pack_request(pfpe_pkg::CMD_READ,  8'd0, 8'd0, pfpe_pkg::PEN_ERASE, 3'd0));
        send_request(pack_request(pfpe_pkg::CMD_READ,  8'd255, 8'd255, PEN_UNUSED, 3'd7));
        send_request(pack_request(pfpe_pkg::CMD_POINT, 8'd0, 8'd0, PEN_UNUSED, 3'd0));
        send_request(pack_request(pfpe_pkg::CMD_READ,  8'd0, 8'd0, pfpe_pkg::PEN_ERASE, 3'd0));
        send_request(pack_request(pfpe_pkg::CMD_FILL,  8'd0, 8'd0, pfpe_pkg::PEN_SET, 3'd0));
        send_request(pack_request(pfpe_pkg::CMD_POINT, 8'd64, 8'd31, pfpe_pkg::PEN_ERASE, 3'd0));
        send_request(pack_request(pfpe_pkg::CMD_POINT, 8'd127, 8'd63, pfpe_pkg::PEN_INVERT, 3'd0));
        send_request(pack_request(pfpe_pkg::CMD_READ,  8'd0, 8'd0, pfpe_pkg::PEN_ERASE, 3'd3));
        send_request(pack_request(pfpe_pkg::CMD_READ,  8'd0, 8'd0, pfpe_pkg::PEN_ERASE, 3'd7));
        send_request(pack_request(pfpe_pkg::CMD_FILL,  8'd0, 8'd0, pfpe_pkg::PEN_INVERT, 3'd0));
        send_request(pack_request(pfpe_pkg::CMD_FILL,  8'd0, 8'd0, PEN_UNUSED, 3'd0));
        send_request(pack_request(CMD_UNUSED, 8'd255, 8'd255, PEN_UNUSED, 3'd7));
        send_request(pack_request(pfpe_pkg::CMD_READ,  8'd0, 8'd0, pfpe_pkg::PEN_ERASE, 3'd5));
        send_request(pack_request(pfpe_pkg::CMD_FILL,  8'd0, 8'd0, pfpe_pkg::PEN_ERASE, 3'd0));
        send_request(pack_request(pfpe_pkg::CMD_READ,  8'd0, 8'd0, pfpe_pkg::PEN_ERASE, 3'd7));

        // Random part; the idle pattern swaps sides, then idling stops.
        for (req_idx = 0; req_idx < RANDOM_REQUESTS; req_idx++) begin
            if (req_idx == 40) begin
                send_idle_pct = 83;
                recv_idle_pct = 8;
            end else if (req_idx == 100) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            send_request(random_request());
        end
        s_tvalid <= 1'b0;

        // Wait for every readout word, then let a trailing fill finish.
        while (pending != 0) begin
            @(negedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
